/* rtl/abcs_pkg.sv */
// Package: shared types and constants of the ADC bridge command unit.
`timescale 1ns / 1ps

package abcs_pkg;

    // Sizing
    localparam int CHANNEL_COUNT = 5;   // channels reported by count and get-all (1..8)
    localparam int REPORT_SLOTS  = 8;   // sample words in a get-all run (1..16)
    localparam int CONV_INPUTS   = 5;   // converter readings carried by each item
    localparam int MASK_W        = 8;
    localparam int SAMPLE_W      = 10;
    localparam int CONV_W        = 12;
    localparam int WORD_W        = 16;
    localparam int ARG_W         = 16;
    localparam int PERIOD_W      = 26;
    localparam int SLOT_W        = $clog2(REPORT_SLOTS + 1);
    localparam int Q_DEPTH       = 2;
    localparam int Q_AW          = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW          = $clog2(Q_DEPTH + 1);

    // Input action codes
    localparam logic [3:0] ACT_COUNT    = 4'd0;
    localparam logic [3:0] ACT_RES      = 4'd1;
    localparam logic [3:0] ACT_CHAN_EN  = 4'd2;
    localparam logic [3:0] ACT_CHAN_DIS = 4'd3;
    localparam logic [3:0] ACT_ENABLE   = 4'd4;
    localparam logic [3:0] ACT_DISABLE  = 4'd5;
    localparam logic [3:0] ACT_GET_VAL  = 4'd6;
    localparam logic [3:0] ACT_GET_ALL  = 4'd7;
    localparam logic [3:0] ACT_SET_CFG  = 4'd8;
    localparam logic [3:0] ACT_TICK     = 4'd9;

    // Minimum request lengths and fixed values
    localparam logic [2:0]          LEN_MIN_CMD = 3'd1;
    localparam logic [2:0]          LEN_MIN_ARG = 3'd2;
    localparam logic [2:0]          LEN_MIN_CFG = 3'd5;
    localparam logic [ARG_W-1:0]    RES_BITS    = 16'd10;
    localparam logic [9:0]          MS_TO_US    = 10'd1000;

    typedef enum logic [3:0] {
        OP_COUNT    = 4'd0,
        OP_RES      = 4'd1,
        OP_CHAN_EN  = 4'd2,
        OP_CHAN_DIS = 4'd3,
        OP_ENABLE   = 4'd4,
        OP_DISABLE  = 4'd5,
        OP_GET_VAL  = 4'd6,
        OP_GET_ALL  = 4'd7,
        OP_SET_CFG  = 4'd8,
        OP_TICK     = 4'd9,
        OP_FAIL     = 4'd10
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ACTIVE = 2'd1,
        MODE_STREAM = 2'd2
    } mode_t;

    // Decoded item handed from the decoder to the executor
    typedef struct packed {
        op_t                                     op;
        logic                                    chan_ok;  // channel below 8
        logic [2:0]                              chan;
        logic [ARG_W-1:0]                        arg;
        logic [CONV_INPUTS-1:0][SAMPLE_W-1:0]    rd;       // readings >> 2
    } cmd_t;

endpackage

/* rtl/abcs_front.sv */
// Decoder: unpacks an input item and resolves every mode-independent check.
`timescale 1ns / 1ps

module abcs_front
    import abcs_pkg::*;
(
    input  logic [7:0]  s_tuser,   // [3:0] action
    input  logic [95:0] s_tdata,   // req_len, port, channel, argument, conv_ch0..conv_ch4
    output cmd_t        cmd
);

    logic [3:0]       action;
    logic [2:0]       req_len;
    logic [7:0]       port;
    logic [7:0]       channel;
    logic [ARG_W-1:0] argument;
    logic             hdr_ok;

    assign action   = s_tuser[3:0];
    assign req_len  = s_tdata[2:0];
    assign port     = s_tdata[10:3];
    assign channel  = s_tdata[18:11];
    assign argument = s_tdata[34:19];
    assign hdr_ok   = (req_len >= LEN_MIN_CMD) && (port == 8'd0);

    always_comb begin
        cmd.chan_ok = (channel < 8'd8);
        cmd.chan    = channel[2:0];
        cmd.arg     = argument;
        for (int i = 0; i < CONV_INPUTS; i++) begin
            cmd.rd[i] = s_tdata[35 + i*CONV_W + 2 +: SAMPLE_W];
        end

        cmd.op = OP_FAIL;
        if (action == ACT_TICK) begin
            cmd.op = OP_TICK;
        end else if (hdr_ok) begin
            case (action)
                ACT_COUNT: begin
                    cmd.op = OP_COUNT;
                end
                ACT_RES: begin
                    if (req_len >= LEN_MIN_ARG && argument == RES_BITS) begin
                        cmd.op = OP_RES;
                    end
                end
                ACT_CHAN_EN: begin
                    if (req_len >= LEN_MIN_ARG) begin
                        cmd.op = OP_CHAN_EN;
                    end
                end
                ACT_CHAN_DIS: begin
                    if (req_len >= LEN_MIN_ARG) begin
                        cmd.op = OP_CHAN_DIS;
                    end
                end
                ACT_ENABLE: begin
                    cmd.op = OP_ENABLE;
                end
                ACT_DISABLE: begin
                    cmd.op = OP_DISABLE;
                end
                ACT_GET_VAL: begin
                    if (req_len >= LEN_MIN_ARG && int'(channel) < CHANNEL_COUNT) begin
                        cmd.op = OP_GET_VAL;
                    end
                end
                ACT_GET_ALL: begin
                    cmd.op = OP_GET_ALL;
                end
                ACT_SET_CFG: begin
                    if (req_len >= LEN_MIN_CFG) begin
                        cmd.op = OP_SET_CFG;
                    end
                end
                default: begin
                    cmd.op = OP_FAIL;
                end
            endcase
        end
    end

endmodule

/* rtl/abcs_queue.sv */
// Short FIFO of decoded items between decoder and executor.
`timescale 1ns / 1ps

module abcs_queue
    import abcs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t            mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == Q_CW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (int'(wr_ptr_reg) == Q_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (int'(rd_ptr_reg) == Q_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/abcs_back.sv */
// Executor: owns mode, mask, samples and sampling timer; drives the result register.
`timescale 1ns / 1ps

module abcs_back
    import abcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  cmd_t        head_cmd,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] word
    output logic [7:0]  m_tuser,   // [0] success, [1] word_valid, [2] is_event
    output logic        m_tlast
);

    mode_t                mode_reg, mode_next;
    logic [MASK_W-1:0]    mask_reg, mask_next;
    logic [SAMPLE_W-1:0]  store_reg [CHANNEL_COUNT];
    logic [SAMPLE_W-1:0]  store_next [CHANNEL_COUNT];
    logic [PERIOD_W-1:0]  period_reg, period_next;
    logic [PERIOD_W-1:0]  remain_reg, remain_next;   // ticks left before the deadline
    logic [SLOT_W-1:0]    cnt_reg, cnt_next;         // get-all word position
    logic                 mv_reg, mv_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic                 ok_reg, ok_next;
    logic                 wv_reg, wv_next;
    logic                 ev_reg, ev_next;
    logic                 last_reg, last_next;

    logic                 out_free, go;
    logic [PERIOD_W-1:0]  period_calc;
    logic [SLOT_W-1:0]    slot_idx;
    logic [SAMPLE_W-1:0]  sel_rd, sel_slot;
    logic [SAMPLE_W-1:0]  rd_ext [CHANNEL_COUNT];

    assign out_free    = !mv_reg || m_tready;
    assign go          = head_valid && out_free;
    assign period_calc = PERIOD_W'(head_cmd.arg) * PERIOD_W'(MS_TO_US);
    assign slot_idx    = cnt_reg - 1'b1;

    assign m_tvalid = mv_reg;
    assign m_tdata  = word_reg;
    assign m_tuser  = {5'd0, ev_reg, wv_reg, ok_reg};
    assign m_tlast  = last_reg;

    always_comb begin
        sel_rd   = '0;
        sel_slot = '0;
        for (int i = 0; i < CONV_INPUTS; i++) begin
            if (int'(head_cmd.chan) == i) begin
                sel_rd = head_cmd.rd[i];
            end
        end
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            rd_ext[i] = '0;
            for (int j = 0; j < CONV_INPUTS; j++) begin
                if (j == i) begin
                    rd_ext[i] = head_cmd.rd[j];
                end
            end
            if (int'(slot_idx) == i) begin
                sel_slot = store_reg[i];
            end
        end
    end

    always_comb begin
        mode_next   = mode_reg;
        mask_next   = mask_reg;
        store_next  = store_reg;
        period_next = period_reg;
        remain_next = remain_reg;
        cnt_next    = cnt_reg;
        mv_next     = mv_reg && !m_tready;
        word_next   = word_reg;
        ok_next     = ok_reg;
        wv_next     = wv_reg;
        ev_next     = ev_reg;
        last_next   = last_reg;
        pop         = 1'b0;

        if (go) begin
            pop       = 1'b1;
            mv_next   = 1'b1;
            word_next = '0;
            ok_next   = 1'b1;
            wv_next   = 1'b0;
            ev_next   = 1'b0;
            last_next = 1'b1;
            case (head_cmd.op)
                OP_COUNT: begin
                    word_next = WORD_W'(CHANNEL_COUNT);
                    wv_next   = 1'b1;
                end
                OP_RES: begin
                end
                OP_CHAN_EN, OP_CHAN_DIS: begin
                    if (mode_reg != MODE_IDLE) begin
                        ok_next = 1'b0;
                    end else if (head_cmd.chan_ok) begin
                        mask_next[head_cmd.chan] = (head_cmd.op == OP_CHAN_EN);
                    end
                end
                OP_ENABLE: begin
                    if (mode_reg != MODE_IDLE) begin
                        ok_next = 1'b0;
                    end else begin
                        mode_next = MODE_ACTIVE;
                        wv_next   = 1'b1;
                    end
                end
                OP_DISABLE: begin
                    if (mode_reg == MODE_STREAM) begin
                        ok_next = 1'b0;
                    end else begin
                        mode_next = MODE_IDLE;
                        wv_next   = 1'b1;
                    end
                end
                OP_GET_VAL: begin
                    if (mode_reg != MODE_ACTIVE) begin
                        ok_next = 1'b0;
                    end else begin
                        word_next = WORD_W'(sel_rd);
                        wv_next   = 1'b1;
                    end
                end
                OP_GET_ALL: begin
                    wv_next = 1'b1;
                    if (cnt_reg != '0 && int'(slot_idx) < CHANNEL_COUNT) begin
                        word_next = WORD_W'(sel_slot);
                    end
                    if (int'(cnt_reg) == REPORT_SLOTS) begin
                        cnt_next = '0;
                    end else begin
                        cnt_next  = cnt_reg + 1'b1;
                        last_next = 1'b0;
                        pop       = 1'b0;
                    end
                end
                OP_SET_CFG: begin
                    if (mode_reg == MODE_ACTIVE) begin
                        if (head_cmd.arg != '0) begin
                            period_next = period_calc;
                            remain_next = period_calc;
                            mode_next   = MODE_STREAM;
                            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                                store_next[i] = '0;
                            end
                        end
                    end else if (mode_reg == MODE_STREAM) begin
                        if (head_cmd.arg != '0) begin
                            ok_next = 1'b0;
                        end else begin
                            mode_next = MODE_ACTIVE;
                        end
                    end
                end
                OP_TICK: begin
                    // no result unless the deadline is crossed
                    mv_next = 1'b0;
                    if (mode_reg == MODE_STREAM) begin
                        if (remain_reg == '0) begin
                            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                                if (mask_reg[i]) begin
                                    store_next[i] = rd_ext[i];
                                end
                            end
                            remain_next = period_reg - 1'b1;
                            mv_next     = 1'b1;
                            ev_next     = 1'b1;
                        end else begin
                            remain_next = remain_reg - 1'b1;
                        end
                    end
                end
                default: begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            mask_reg   <= '0;
            period_reg <= '0;
            remain_reg <= '0;
            cnt_reg    <= '0;
            mv_reg     <= 1'b0;
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                store_reg[i] <= '0;
            end
        end else begin
            mode_reg   <= mode_next;
            mask_reg   <= mask_next;
            period_reg <= period_next;
            remain_reg <= remain_next;
            cnt_reg    <= cnt_next;
            mv_reg     <= mv_next;
            store_reg  <= store_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        ok_reg   <= ok_next;
        wv_reg   <= wv_next;
        ev_reg   <= ev_next;
        last_reg <= last_next;
    end

`ifndef NO_ASSERTIONS
    a_remain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_STREAM) |-> (period_reg != '0 && remain_reg <= period_reg))
        else $error("sampling timer out of range while streaming");

    a_cnt_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) |-> (head_valid && head_cmd.op == OP_GET_ALL))
        else $error("get-all position set without a get-all at the head");

    a_mask_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != MODE_IDLE) |=> $stable(mask_reg))
        else $error("channel mask changed outside idle");

    a_event_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && ev_reg) |-> (ok_reg && !wv_reg && last_reg && word_reg == '0))
        else $error("malformed event item");
`endif

endmodule

/* rtl/adc_bridge_command_and_stream_unit.sv */
// Top level: ADC bridge command unit with decoder, item queue and executor.
`timescale 1ns / 1ps

// Each input item is a host command or one microsecond tick, selected by
// s_tuser[3:0]. The decoder checks length, port and opcode on entry and
// writes the decoded item into a two-entry queue; the executor takes the
// queue head, applies the mode rules, updates the state and loads the
// one-deep result register. Commands and ticks retire one per cycle while
// the result register is free or being drained, so ticks can stream in
// back to back; a result is registered and shows in the cycle after its
// item is taken. A get-all holds the head for REPORT_SLOTS + 1 words (9 as
// built), one per cycle while the output is free, and the queue fills
// behind it. A tick that crosses the sampling deadline gives one event
// item (is_event set, last set); other ticks give no item. The sampling
// timer is a countdown reloaded with the period in microseconds, so the
// 64-bit clock is not kept. No clearing pass; control and samples reset.

module adc_bridge_command_and_stream_unit
    import abcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] req_len, [10:3] port, [18:11] channel, [34:19] argument,
    // [46:35] conv_ch0, [58:47] conv_ch1, [70:59] conv_ch2,
    // [82:71] conv_ch3, [94:83] conv_ch4, [95] zero
    input  logic [95:0] s_tdata,
    input  logic [7:0]  s_tuser,   // [3:0] action

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] word
    output logic [7:0]  m_tuser,   // [0] success, [1] word_valid, [2] is_event
    output logic        m_tlast    // last item of the run
);

    cmd_t dec_cmd;
    cmd_t head_cmd;
    logic q_full;
    logic head_valid;
    logic pop;

    assign s_tready = !q_full;

    // Stateless decode of the incoming item
    abcs_front u_front (
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .cmd     (dec_cmd)
    );

    // Decouples acceptance from execution
    abcs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_tvalid),
        .push_cmd   (dec_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Mode rules, state and result register
    abcs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
